// ===== design/dfspw_pkg.sv =====
// Package for the post-order depth-first walker: default sizes,
// command and result types, mode and status codes. No dependencies.
`default_nettype none

package dfspw_pkg;

	localparam int DEF_MAX_VERTICES = 256;
	localparam int DEF_MAX_DEGREE   = 8;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;
	localparam logic [1:0] MODE_NEXT   = 2'd3;

	localparam logic [2:0] ST_FINISHED = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_STORED   = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] source_vertex;
		logic [7:0] target_vertex;
		logic       edge_enabled;
	} cmd_t;

	typedef struct packed {
		logic [8:0] vertex;
		logic [2:0] status;
	} result_t;

endpackage

`default_nettype wire

// ===== design/dfspw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module dfspw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/dfs_postorder_walker.sv =====
// Top level of the post-order depth-first walker: command FSM, walk state,
// visited and list-valid flags. Depends on dfspw_pkg and dfspw_ram.
//
// Usage: drive cmd and raise start; the command transfers at a clock edge
// with start high and busy low. For all but a clear, busy stays high until
// the command is done. Each command yields exactly one result on result,
// marked by done for one cycle; the receiver cannot stall it. num_vertices
// is written through num_vertices_we; the user must do so only while busy
// is low, which the block itself does not enforce.
// Clear graph: result in the cycle after the transfer (edge-list flags
// cleared at once). Append edge: S_APP_RD reads the count, then S_APP_WR
// writes the edge and count and registers the result. Start / next: a step
// enters through S_TOP, which skips visited roots one at a time; S_TOP and
// S_CNT read the edge count after each push, each edge scanned passes
// S_SCAN and S_EDGE (edge RAM read), and after a pop S_POP restores the
// stack top from the stack RAM. Edge store, per-vertex edge counts and
// stack each sit in a RAM with registered read data. Reset: graph empty,
// no vertex visited, stack empty, num_vertices = 1; no RAM needs clearing.
`default_nettype none

module dfs_postorder_walker #(
	parameter int MAX_VERTICES = dfspw_pkg::DEF_MAX_VERTICES,
	parameter int MAX_DEGREE   = dfspw_pkg::DEF_MAX_DEGREE
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire dfspw_pkg::cmd_t   cmd,
	output logic                   done,
	output dfspw_pkg::result_t     result,
	input  wire logic              num_vertices_we,
	input  wire logic [8:0]        num_vertices
);

	import dfspw_pkg::*;

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int PW   = $clog2(MAX_DEGREE + 1);
	localparam int DW   = $clog2(MAX_VERTICES + 1);
	localparam int EDEP = MAX_VERTICES * MAX_DEGREE;
	localparam int AW   = $clog2(EDEP);
	localparam int NMAX = (MAX_VERTICES > 511) ? 511 : MAX_VERTICES;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APP_RD,
		S_APP_WR,
		S_TOP,
		S_CNT,
		S_SCAN,
		S_EDGE,
		S_POP
	} state_t;

	state_t                  state_q;
	cmd_t                    req_q;
	logic [8:0]              num_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] ecv_q;
	logic [DW-1:0]           depth_q;
	logic [8:0]              root_q;
	logic [VW-1:0]           top_v_q;
	logic [PW-1:0]           top_pos_q;
	logic [PW-1:0]           cnt_q;
	logic                    done_q;
	result_t                 result_q;

	logic [8:0]    n_eff;
	logic [VW-1:0] src_idx;
	logic [PW-1:0] app_cnt;
	logic          app_bad;

	logic          ec_we;
	logic [VW-1:0] ec_raddr;
	logic [PW-1:0] ec_rdata;

	logic          ed_we;
	logic [AW-1:0] ed_waddr;
	logic [AW-1:0] ed_raddr;
	logic [8:0]    ed_rdata;
	logic [7:0]    e_tgt;
	logic          e_en;
	logic          e_take;

	logic           st_we;
	logic [VW-1:0]  st_waddr;
	logic [VW-1:0]  st_raddr;
	logic [VW+PW-1:0] st_rdata;

	assign n_eff   = (num_q > 9'(NMAX)) ? 9'(NMAX) : num_q;
	assign src_idx = VW'(req_q.source_vertex);
	assign app_cnt = ecv_q[src_idx] ? ec_rdata : '0;
	assign app_bad = ({1'b0, req_q.source_vertex} >= n_eff)
		|| ({1'b0, req_q.target_vertex} >= n_eff)
		|| (app_cnt >= PW'(MAX_DEGREE));

	assign ec_we    = (state_q == S_APP_WR) && !app_bad;
	assign ec_raddr = (state_q == S_APP_RD) ? src_idx : top_v_q;

	assign ed_we    = ec_we;
	assign ed_waddr = AW'(src_idx) * AW'(MAX_DEGREE) + AW'(app_cnt);
	assign ed_raddr = AW'(top_v_q) * AW'(MAX_DEGREE) + AW'(top_pos_q);
	assign e_tgt    = ed_rdata[7:0];
	assign e_en     = ed_rdata[8];
	assign e_take   = e_en && ({1'b0, e_tgt} < n_eff) && !visited_q[VW'(e_tgt)]
		&& (depth_q < DW'(MAX_VERTICES));

	assign st_we    = (state_q == S_EDGE) && e_take;
	assign st_waddr = VW'(depth_q - DW'(1));
	assign st_raddr = VW'(depth_q - DW'(2));

	dfspw_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_count_ram (
		.clk   (clk),
		.we    (ec_we),
		.waddr (src_idx),
		.wdata (app_cnt + PW'(1)),
		.raddr (ec_raddr),
		.rdata (ec_rdata)
	);

	dfspw_ram #(.WIDTH(9), .DEPTH(EDEP)) u_edge_ram (
		.clk   (clk),
		.we    (ed_we),
		.waddr (ed_waddr),
		.wdata ({req_q.edge_enabled, req_q.target_vertex}),
		.raddr (ed_raddr),
		.rdata (ed_rdata)
	);

	dfspw_ram #(.WIDTH(VW + PW), .DEPTH(MAX_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata ({top_v_q, top_pos_q}),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 9'd1;
		end else if (num_vertices_we) begin
			num_q <= num_vertices;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			visited_q <= '0;
			ecv_q     <= '0;
			depth_q   <= '0;
			root_q    <= '0;
			top_v_q   <= '0;
			top_pos_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
			req_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= cmd;
						unique case (cmd.mode)
							MODE_CLEAR: begin
								ecv_q    <= '0;
								done_q   <= 1'b1;
								result_q <= '{vertex: 9'd0, status: ST_CLEARED};
							end
							MODE_APPEND: begin
								state_q <= S_APP_RD;
							end
							MODE_START: begin
								visited_q <= '0;
								depth_q   <= '0;
								root_q    <= '0;
								state_q   <= S_TOP;
							end
							MODE_NEXT: begin
								state_q <= S_TOP;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_APP_RD: begin
					state_q <= S_APP_WR;
				end
				S_APP_WR: begin
					done_q         <= 1'b1;
					result_q.vertex <= {1'b0, req_q.source_vertex};
					if (app_bad) begin
						result_q.status <= ST_DROPPED;
					end else begin
						ecv_q[src_idx]  <= 1'b1;
						result_q.status <= ST_STORED;
					end
					state_q <= S_IDLE;
				end
				S_TOP: begin
					priority if (depth_q != '0) begin
						state_q <= S_CNT;
					end else if (root_q >= n_eff) begin
						done_q   <= 1'b1;
						result_q <= '{vertex: n_eff, status: ST_COMPLETE};
						state_q  <= S_IDLE;
					end else if (visited_q[VW'(root_q)]) begin
						root_q <= root_q + 9'd1;
					end else begin
						visited_q[VW'(root_q)] <= 1'b1;
						top_v_q   <= VW'(root_q);
						top_pos_q <= '0;
						depth_q   <= DW'(1);
					end
				end
				S_CNT: begin
					cnt_q   <= ecv_q[top_v_q] ? ec_rdata : '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if ((top_pos_q < cnt_q) && (top_pos_q < PW'(MAX_DEGREE))) begin
						top_pos_q <= top_pos_q + PW'(1);
						state_q   <= S_EDGE;
					end else begin
						depth_q  <= depth_q - DW'(1);
						done_q   <= 1'b1;
						result_q <= '{vertex: 9'(top_v_q), status: ST_FINISHED};
						state_q  <= (depth_q > DW'(1)) ? S_POP : S_IDLE;
					end
				end
				S_EDGE: begin
					if (e_take) begin
						visited_q[VW'(e_tgt)] <= 1'b1;
						top_v_q   <= VW'(e_tgt);
						top_pos_q <= '0;
						depth_q   <= depth_q + DW'(1);
						state_q   <= S_TOP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_POP: begin
					top_v_q   <= st_rdata[VW+PW-1:PW];
					top_pos_q <= st_rdata[PW-1:0];
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.mode != MODE_CLEAR) |=> busy)
		else $error("busy low after a non-clear transfer");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_VERTICES))
		else $error("stack depth beyond capacity");

	a_complete_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_COMPLETE) |-> (depth_q == '0))
		else $error("complete reported with a nonempty stack");

	a_edge_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EDGE) |-> ($past(state_q) == S_SCAN))
		else $error("edge check without an issued edge read");

endmodule

`default_nettype wire

// ===== tb/tb_dfs_postorder_walker.sv =====
// Testbench for dfs_postorder_walker: directed and random command streams
// checked against an in-bench post-order walk predictor. Needs dfspw_pkg.

import dfspw_pkg::*;

class walk_checker;
	logic [7:0]  edge_tgt [DEF_MAX_VERTICES*DEF_MAX_DEGREE];
	bit          edge_on [DEF_MAX_VERTICES*DEF_MAX_DEGREE];
	int unsigned edge_num [DEF_MAX_VERTICES];
	bit          seen [DEF_MAX_VERTICES];
	int unsigned stack_v [DEF_MAX_VERTICES];
	int unsigned stack_pos [DEF_MAX_VERTICES];
	int unsigned depth;
	int unsigned root_next;
	int unsigned vcount_reg;
	result_t     results_due [$];
	int          errors;

	function new();
		depth = 0;
		root_next = 0;
		vcount_reg = 1;
		errors = 0;
	endfunction

	function int unsigned active_vertices();
		return (vcount_reg > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : vcount_reg;
	endfunction

	function void set_vertex_count(logic [8:0] v);
		vcount_reg = v;
	endfunction

	function result_t advance_walk();
		int unsigned n, top, v, pos, t, idx;
		bit pushed;
		result_t r;
		n = active_vertices();
		forever begin
			while (depth > 0) begin
				top = depth - 1;
				v = stack_v[top] % DEF_MAX_VERTICES;
				pos = stack_pos[top];
				pushed = 0;
				while (pos < edge_num[v] && pos < DEF_MAX_DEGREE && !pushed) begin
					idx = v * DEF_MAX_DEGREE + pos;
					t = edge_tgt[idx];
					pos++;
					if (edge_on[idx] && t < n && !seen[t] && depth < DEF_MAX_VERTICES) begin
						seen[t] = 1;
						stack_pos[top] = pos;
						stack_v[depth] = t;
						stack_pos[depth] = 0;
						depth++;
						pushed = 1;
					end
				end
				if (!pushed) begin
					depth--;
					r.vertex = v[8:0];
					r.status = ST_FINISHED;
					return r;
				end
			end
			if (root_next >= n) begin
				r.vertex = n[8:0];
				r.status = ST_COMPLETE;
				return r;
			end
			if (seen[root_next]) begin
				root_next++;
			end else begin
				seen[root_next] = 1;
				stack_v[0] = root_next;
				stack_pos[0] = 0;
				depth = 1;
			end
		end
	endfunction

	function void note_command(cmd_t c);
		int unsigned n, s, g, idx;
		result_t r;
		n = active_vertices();
		s = c.source_vertex;
		g = c.target_vertex;
		case (c.mode)
			MODE_CLEAR: begin
				foreach (edge_num[i])
					edge_num[i] = 0;
				r.vertex = '0;
				r.status = ST_CLEARED;
			end
			MODE_APPEND: begin
				r.vertex = s[8:0];
				if (s >= n || g >= n || edge_num[s] >= DEF_MAX_DEGREE) begin
					r.status = ST_DROPPED;
				end else begin
					idx = s * DEF_MAX_DEGREE + edge_num[s];
					edge_tgt[idx] = g[7:0];
					edge_on[idx] = c.edge_enabled;
					edge_num[s]++;
					r.status = ST_STORED;
				end
			end
			default: begin
				if (c.mode == MODE_START) begin
					foreach (seen[i])
						seen[i] = 0;
					depth = 0;
					root_next = 0;
				end
				r = advance_walk();
			end
		endcase
		results_due.push_back(r);
	endfunction

	function void report(string what, result_t want, result_t got);
		errors++;
		if (errors <= 10)
			$display("%s: expected vertex %0d status %0d, got vertex %0d status %0d",
				what, want.vertex, want.status, got.vertex, got.status);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (results_due.size() == 0) begin
			want = '0;
			report("unexpected result", want, got);
		end else begin
			want = results_due.pop_front();
			if (got.vertex !== want.vertex || got.status !== want.status)
				report("result mismatch", want, got);
		end
	endfunction

	function void check_drained();
		if (results_due.size() != 0) begin
			errors++;
			if (errors <= 10)
				$display("%0d results never arrived", results_due.size());
		end
	endfunction
endclass

module tb_dfs_postorder_walker;

	localparam int LIMIT = 3000000;
	localparam int ITEMS = 750;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        num_vertices_we;
	logic [8:0]  num_vertices;

	walk_checker sb;
	int          cycles = 0;
	int          items_sent = 0;
	bit          no_idle = 0;

	dfs_postorder_walker i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.done           (done),
		.result         (result),
		.num_vertices_we(num_vertices_we),
		.num_vertices   (num_vertices)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_dfs_postorder_walker: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	function automatic cmd_t mk(logic [1:0] m, logic [7:0] s, logic [7:0] t, logic e);
		cmd_t c;
		c.mode = m;
		c.source_vertex = s;
		c.target_vertex = t;
		c.edge_enabled = e;
		return c;
	endfunction

	function automatic cmd_t any_cmd();
		return mk($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 1));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic issue(cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
		items_sent++;
	endtask

	task automatic write_count(logic [8:0] v);
		start <= 0;
		do @(posedge clk); while (sb.results_due.size() != 0 || busy);
		num_vertices_we <= 1;
		num_vertices <= v;
		@(posedge clk);
		num_vertices_we <= 0;
		sb.set_vertex_count(v);
	endtask

	task automatic add_edge(int unsigned n);
		if (n == 0 || $urandom_range(0, 9) == 0)
			issue(mk(MODE_APPEND, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 1)));
		else
			issue(mk(MODE_APPEND, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
				$urandom_range(0, 7) != 0));
	endtask

	task automatic run_phase();
		logic [8:0]  nv;
		int unsigned n, edges, steps, r, hub;
		r = $urandom_range(0, 99);
		if (r < 6)
			nv = 0;
		else if (r < 12)
			nv = 1;
		else if (r < 18)
			nv = 256;
		else if (r < 24)
			nv = $urandom_range(257, 511);
		else if (r < 32)
			nv = $urandom_range(17, 80);
		else
			nv = $urandom_range(2, 16);
		write_count(nv);
		no_idle = ($urandom_range(0, 4) == 0);
		n = (nv > 256) ? 256 : nv;
		if ($urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 4) != 0)
				issue(mk(MODE_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 1)));
			edges = (n <= 1) ? $urandom_range(0, 3) : $urandom_range(n / 2, 2 * n);
			if (edges > 40)
				edges = $urandom_range(20, 40);
			repeat (edges) add_edge(n);
			if (n > 0 && $urandom_range(0, 4) == 0) begin
				hub = $urandom_range(0, n - 1);
				repeat ($urandom_range(8, 10))
					issue(mk(MODE_APPEND, hub, $urandom_range(0, n - 1), $urandom_range(0, 1)));
			end
			issue(mk(MODE_START, $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 1)));
		end
		if (n >= 60 && $urandom_range(0, 3) != 0)
			steps = $urandom_range(10, 50);
		else
			steps = n + $urandom_range(1, 3);
		repeat (steps) begin
			if ($urandom_range(0, 15) == 0)
				issue(any_cmd());
			else
				issue(mk(MODE_NEXT, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 1)));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		cmd = '0;
		num_vertices_we = 0;
		num_vertices = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		issue(mk(MODE_NEXT, 8'd0, 8'd0, 1'b0));
		issue(mk(MODE_CLEAR, 8'hFF, 8'hFF, 1'b1));
		issue(mk(MODE_APPEND, 8'd0, 8'd0, 1'b1));
		issue(mk(MODE_APPEND, 8'd255, 8'd0, 1'b1));
		issue(mk(MODE_APPEND, 8'd0, 8'd255, 1'b0));
		issue(mk(MODE_START, 8'd0, 8'd0, 1'b0));
		issue(mk(MODE_NEXT, 8'd0, 8'd0, 1'b0));
		issue(mk(MODE_NEXT, 8'd0, 8'd0, 1'b0));
		write_count(9'd0);
		issue(mk(MODE_NEXT, 8'd0, 8'd0, 1'b0));
		issue(mk(MODE_APPEND, 8'd0, 8'd0, 1'b1));
		write_count(9'd511);
		repeat (9) issue(mk(MODE_APPEND, 8'd255, 8'd0, 1'b1));
		issue(mk(MODE_APPEND, 8'd0, 8'd255, 1'b1));
		issue(mk(MODE_START, 8'd0, 8'd0, 1'b0));
		issue(mk(MODE_NEXT, 8'd0, 8'd0, 1'b0));

		while (items_sent < ITEMS)
			run_phase();

		start <= 0;
		do @(posedge clk); while (sb.results_due.size() != 0);
		repeat (50) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("tb_dfs_postorder_walker: clean");
		else
			$display("tb_dfs_postorder_walker: errors");
		$finish;
	end

endmodule
